>>> sv/arot_pkg.sv
`default_nettype none
package arot_pkg;

   localparam int SINCOS_STAGES_DEF = 16;
   localparam int ANGLE_BITS_DEF    = 16;
   localparam int ATAN_ENTRIES      = 24;

   // Angle to phase scale factors: 2^32 / 23040 and 2^20 / (2 pi).
   localparam logic [17:0] DEG_SCALE = 18'd186414;
   localparam logic [17:0] RAD_SCALE = 18'd166886;

   // CORDIC datapath width; x and y are Q2.30 with headroom.
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

   localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef enum logic [1:0] {
      CSR_OFFSET_X   = 2'd0,
      CSR_OFFSET_Y   = 2'd1,
      CSR_OFFSET_Z   = 2'd2,
      CSR_ANGLE_MODE = 2'd3
   } csr_index_type;

   // Point data that rides along with the angle through the sine/cosine pipe.
   typedef struct packed {
      axis_type           axis;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } side_type;

   typedef struct packed {
      logic                 valid;
      logic [1:0]           quad;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      side_type             side;
   } cordic_type;

   // Stages beyond the table use a step of zero.
   function automatic logic [31:0] atan_step(input int unsigned i);
      logic [31:0] step;
      step = 32'd0;
      if (i < ATAN_ENTRIES) begin
         step = ATAN_TURNS[i[4:0]];
      end
      return step;
   endfunction

endpackage
`default_nettype wire

>>> sv/arot_phase.sv
`default_nettype none
module arot_phase #(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic signed [15:0]    in_angle,
   input  wire logic                  in_degrees,
   input  wire arot_pkg::side_type    in_side,
   output arot_pkg::cordic_type       out_stage
);
   import arot_pkg::*;

   localparam logic [31:0] HALF = 32'd1 << (31 - ANGLE_BITS);
   localparam logic [31:0] LOW  = (32'd1 << (32 - ANGLE_BITS)) - 32'd1;

   logic              valid_ff;
   logic [31:0]       phase_ff;
   side_type          side_ff;
   logic signed [34:0] prod;

   logic [31:0] phase_round;
   logic [31:0] phase_shift;
   logic [1:0]  quad;
   logic [31:0] resid;
   cordic_type  stage_in;
   cordic_type  stage_ff;

   // The phase wraps modulo one turn, so only the low 32 bits matter.
   assign prod = in_angle * $signed({1'b0, (in_degrees ? DEG_SCALE : RAD_SCALE)});

   always_ff @(posedge clock) begin
      valid_ff <= in_valid;
      phase_ff <= prod[31:0];
      side_ff  <= in_side;
      if (reset) begin
         valid_ff <= 1'b0;
      end
   end

   always_comb begin
      phase_round    = (phase_ff + HALF) & ~LOW;
      phase_shift    = phase_round + 32'h2000_0000;
      quad           = phase_shift[31:30];
      resid          = phase_round - {quad, 30'd0};
      stage_in.valid = valid_ff;
      stage_in.quad  = quad;
      stage_in.x     = CORDIC_X0;
      stage_in.y     = '0;
      stage_in.z     = {{(CW-32){resid[31]}}, resid};
      stage_in.side  = side_ff;
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign out_stage = stage_ff;

endmodule
`default_nettype wire

>>> sv/arot_cordic.sv
`default_nettype none
module arot_cordic #(
   parameter int SINCOS_STAGES = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire arot_pkg::cordic_type in_stage,
   output arot_pkg::cordic_type      out_stage
);
   import arot_pkg::*;

   cordic_type stage_ff [SINCOS_STAGES];

   for (genvar i = 0; i < SINCOS_STAGES; i++) begin : g_stage
      cordic_type             src;
      cordic_type             stage_in;
      logic signed [CW-1:0]   x_shift;
      logic signed [CW-1:0]   y_shift;
      logic signed [CW-1:0]   step;

      if (i == 0) begin : g_first
         assign src = in_stage;
      end else begin : g_next
         assign src = stage_ff[i-1];
      end

      always_comb begin
         x_shift  = $signed(src.x) >>> i;
         y_shift  = $signed(src.y) >>> i;
         step     = $signed({{(CW-32){1'b0}}, atan_step(i)});
         stage_in = src;
         // Rotate toward zero residual angle.
         if (!src.z[CW-1]) begin
            stage_in.x = src.x - y_shift;
            stage_in.y = src.y + x_shift;
            stage_in.z = src.z - step;
         end else begin
            stage_in.x = src.x + y_shift;
            stage_in.y = src.y - x_shift;
            stage_in.z = src.z + step;
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[i] <= stage_in;
         if (reset) begin
            stage_ff[i].valid <= 1'b0;
         end
      end
   end

   assign out_stage = stage_ff[SINCOS_STAGES-1];

endmodule
`default_nettype wire

>>> sv/arot_xform.sv
`default_nettype none
module arot_xform (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire arot_pkg::cordic_type in_stage,
   input  wire logic signed [31:0]   offset_x,
   input  wire logic signed [31:0]   offset_y,
   input  wire logic signed [31:0]   offset_z,
   output logic                      out_valid,
   output logic signed [31:0]        out_x,
   output logic signed [31:0]        out_y,
   output logic signed [31:0]        out_z,
   output logic                      out_saturated
);
   import arot_pkg::*;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] value;
   } sat_type;

   function automatic sat_type clamp32(input logic signed [36:0] v);
      sat_type r;
      r.hit   = 1'b0;
      r.value = v[31:0];
      if (v > 37'sd2147483647) begin
         r.hit   = 1'b1;
         r.value = 32'sh7FFF_FFFF;
      end else if (v < -37'sd2147483648) begin
         r.hit   = 1'b1;
         r.value = 32'sh8000_0000;
      end
      return r;
   endfunction

   function automatic logic signed [16:0] round_q15(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] t;
      logic signed [CW-1:0] r;
      t = v + CW'(16384);
      r = t >>> 15;
      if (r > CW'(32767)) begin
         return 17'sd32767;
      end else if (r < -CW'(32768)) begin
         return -17'sd32768;
      end
      return r[16:0];
   endfunction

   // Stage 1: quadrant fix, rounding to Q1.15 and operand selection.
   logic                 t1_valid_ff;
   axis_type             t1_axis_ff;
   logic signed [16:0]   t1_c_ff, t1_s_ff;
   logic signed [31:0]   t1_a_ff, t1_b_ff, t1_k_ff;
   logic signed [CW-1:0] cq, sq;
   logic signed [16:0]   c_in, s_in;
   logic signed [31:0]   a_in, b_in, k_in;

   always_comb begin
      cq = in_stage.x;
      sq = in_stage.y;
      case (in_stage.quad)
         2'd1: begin
            cq = -in_stage.y;
            sq = in_stage.x;
         end
         2'd2: begin
            cq = -in_stage.x;
            sq = -in_stage.y;
         end
         2'd3: begin
            cq = in_stage.y;
            sq = -in_stage.x;
         end
         default: begin
         end
      endcase
      c_in = round_q15(cq);
      s_in = round_q15(sq);
      // The two rotated coordinates are a and b, the axis coordinate is k.
      case (in_stage.side.axis)
         AXIS_Y: begin
            a_in = in_stage.side.pz;
            b_in = in_stage.side.px;
            k_in = in_stage.side.py;
         end
         AXIS_Z: begin
            a_in = in_stage.side.px;
            b_in = in_stage.side.py;
            k_in = in_stage.side.pz;
         end
         AXIS_NONE: begin
            a_in = in_stage.side.py;
            b_in = in_stage.side.pz;
            k_in = in_stage.side.px;
            c_in = 17'sd32768;
            s_in = 17'sd0;
         end
         default: begin
            a_in = in_stage.side.py;
            b_in = in_stage.side.pz;
            k_in = in_stage.side.px;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      t1_valid_ff <= in_stage.valid;
      t1_axis_ff  <= in_stage.side.axis;
      t1_c_ff     <= c_in;
      t1_s_ff     <= s_in;
      t1_a_ff     <= a_in;
      t1_b_ff     <= b_in;
      t1_k_ff     <= k_in;
      if (reset) begin
         t1_valid_ff <= 1'b0;
      end
   end

   // Stage 2: the four products.
   logic               t2_valid_ff;
   axis_type           t2_axis_ff;
   logic signed [48:0] t2_ca_ff, t2_sb_ff, t2_sa_ff, t2_cb_ff;
   logic signed [31:0] t2_k_ff;

   always_ff @(posedge clock) begin
      t2_valid_ff <= t1_valid_ff;
      t2_axis_ff  <= t1_axis_ff;
      t2_ca_ff    <= t1_c_ff * t1_a_ff;
      t2_sb_ff    <= t1_s_ff * t1_b_ff;
      t2_sa_ff    <= t1_s_ff * t1_a_ff;
      t2_cb_ff    <= t1_c_ff * t1_b_ff;
      t2_k_ff     <= t1_k_ff;
      if (reset) begin
         t2_valid_ff <= 1'b0;
      end
   end

   // Stage 3: row sums with the offset and the rounding constant.
   logic               t3_valid_ff;
   axis_type           t3_axis_ff;
   logic signed [51:0] t3_acc_a_ff, t3_acc_b_ff;
   logic signed [32:0] t3_k_ff;
   logic signed [31:0] off_a, off_b, off_k;
   logic signed [51:0] acc_a_in, acc_b_in;

   always_comb begin
      case (t2_axis_ff)
         AXIS_Y: begin
            off_a = offset_z;
            off_b = offset_x;
            off_k = offset_y;
         end
         AXIS_Z: begin
            off_a = offset_x;
            off_b = offset_y;
            off_k = offset_z;
         end
         default: begin
            off_a = offset_y;
            off_b = offset_z;
            off_k = offset_x;
         end
      endcase
      acc_a_in = 52'(t2_ca_ff) - 52'(t2_sb_ff) + (52'(off_a) <<< 15) + 52'sd16384;
      acc_b_in = 52'(t2_sa_ff) + 52'(t2_cb_ff) + (52'(off_b) <<< 15) + 52'sd16384;
   end

   always_ff @(posedge clock) begin
      t3_valid_ff <= t2_valid_ff;
      t3_axis_ff  <= t2_axis_ff;
      t3_acc_a_ff <= acc_a_in;
      t3_acc_b_ff <= acc_b_in;
      t3_k_ff     <= 33'(t2_k_ff) + 33'(off_k);
      if (reset) begin
         t3_valid_ff <= 1'b0;
      end
   end

   // Stage 4: scale back, saturate and put the coordinates in place.
   logic               valid_ff;
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic               sat_ff;
   logic signed [51:0] sh_a, sh_b;
   sat_type            ra, rb, rk;
   logic signed [31:0] x_in, y_in, z_in;

   always_comb begin
      sh_a = t3_acc_a_ff >>> 15;
      sh_b = t3_acc_b_ff >>> 15;
      ra   = clamp32(sh_a[36:0]);
      rb   = clamp32(sh_b[36:0]);
      rk   = clamp32(37'(t3_k_ff));
      case (t3_axis_ff)
         AXIS_Y: begin
            x_in = rb.value;
            y_in = rk.value;
            z_in = ra.value;
         end
         AXIS_Z: begin
            x_in = ra.value;
            y_in = rb.value;
            z_in = rk.value;
         end
         default: begin
            x_in = rk.value;
            y_in = ra.value;
            z_in = rb.value;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      valid_ff <= t3_valid_ff;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      sat_ff   <= ra.hit | rb.hit | rk.hit;
      if (reset) begin
         valid_ff <= 1'b0;
      end
   end

   assign out_valid     = valid_ff;
   assign out_x         = x_ff;
   assign out_y         = y_ff;
   assign out_z         = z_ff;
   assign out_saturated = sat_ff;

endmodule
`default_nettype wire

>>> sv/axis_rotation_translation_top.sv
// An accepted start passes the phase registers, the CORDIC stages and the matrix stages before the rsp_valid strobe.
// Throughput: one point per cycle; busy stays low, since every stage of the
// phase, CORDIC and matrix pipeline advances on each clock.
// The CORDIC stage count sets the latency; the results cannot be stalled.
// Synchronous reset clears all valid bits, zeroes the offsets and selects degrees.
`default_nettype none
module axis_rotation_translation_top #(
   parameter int SINCOS_STAGES = arot_pkg::SINCOS_STAGES_DEF,
   parameter int ANGLE_BITS    = arot_pkg::ANGLE_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_axis,
   input  wire logic signed [15:0] req_angle,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic                    rsp_saturated,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import arot_pkg::*;

   logic signed [31:0] offset_x_ff, offset_y_ff, offset_z_ff;
   logic               degrees_ff;
   side_type           side;
   cordic_type         phase_out;
   cordic_type         cordic_out;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
         degrees_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_OFFSET_X:   offset_x_ff <= csr_data;
            CSR_OFFSET_Y:   offset_y_ff <= csr_data;
            CSR_OFFSET_Z:   offset_z_ff <= csr_data;
            CSR_ANGLE_MODE: degrees_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign side.axis = axis_type'(req_axis);
   assign side.px   = req_point_x;
   assign side.py   = req_point_y;
   assign side.pz   = req_point_z;

   arot_phase #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_angle   (req_angle),
      .in_degrees (degrees_ff),
      .in_side    (side),
      .out_stage  (phase_out)
   );

   arot_cordic #(
      .SINCOS_STAGES (SINCOS_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (phase_out),
      .out_stage (cordic_out)
   );

   arot_xform u_xform (
      .clock         (clock),
      .reset         (reset),
      .in_stage      (cordic_out),
      .offset_x      (offset_x_ff),
      .offset_y      (offset_y_ff),
      .offset_z      (offset_z_ff),
      .out_valid     (rsp_valid),
      .out_x         (rsp_out_x),
      .out_y         (rsp_out_y),
      .out_z         (rsp_out_z),
      .out_saturated (rsp_saturated)
   );

endmodule
`default_nettype wire
